// ===== hw/rtl/acwm_pkg.sv =====
`default_nettype none
package acwm_pkg;

  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_NEXT   = 3'd1;
  localparam logic [2:0] OP_SELECT = 3'd2;
  localparam logic [2:0] OP_PREV   = 3'd3;
  localparam logic [2:0] OP_LOAD   = 3'd4;

  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_ARMED   = 2'd1;
  localparam logic [1:0] MODE_RINGING = 2'd2;

  localparam logic [1:0] PAGE_CLOCK  = 2'd0;
  localparam logic [1:0] PAGE_ENTRY  = 2'd1;
  localparam logic [1:0] PAGE_RESET  = 2'd2;
  localparam logic [1:0] PAGE_EDITOR = 2'd3;

  localparam logic [1:0] ITEM_ENABLE = 2'd0;
  localparam logic [1:0] ITEM_HOUR   = 2'd1;
  localparam logic [1:0] ITEM_MINUTE = 2'd2;
  localparam logic [1:0] ITEM_BACK   = 2'd3;

  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINSEC_MAX = 6'd59;
  localparam logic [5:0] RING_SECS  = 6'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic [4:0] load_hour;
    logic [5:0] load_minute;
    logic [5:0] load_second;
  } evt_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic       buzzer;
    logic [1:0] alarm_mode;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
    logic [1:0] menu_page;
    logic [1:0] edit_item;
    logic       editing;
    logic       resync_request;
  } res_t;

  typedef struct packed {
    logic [5:0] sec_count;
    logic [5:0] min_count;
    logic [4:0] hour_count;
    logic [4:0] alarm_hour;
    logic [5:0] alarm_minute;
    logic [1:0] alarm_mode;
    logic       buzzer;
    logic [1:0] page;
    logic [1:0] item;
    logic       editing;
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/acwm_step.sv =====
`default_nettype none
module acwm_step (
  input  acwm_pkg::state_t st,
  input  acwm_pkg::evt_t   evt,
  output acwm_pkg::state_t st_next,
  output logic             wrap
);
  import acwm_pkg::*;

  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic [5:0] hour_inc;
  logic [5:0] s;
  logic [5:0] m;
  logic [4:0] h;
  logic       up;

  always_comb begin
    st_next  = st;
    wrap     = 1'b0;
    sec_inc  = {1'b0, st.sec_count} + 7'd1;
    min_inc  = {1'b0, st.min_count};
    hour_inc = {1'b0, st.hour_count};
    s        = sec_inc[5:0];
    m        = st.min_count;
    h        = st.hour_count;
    up       = (evt.opcode == OP_NEXT);
    case (evt.opcode)
      OP_TICK: begin
        if (sec_inc >= 7'd60) begin
          s       = 6'd0;
          min_inc = {1'b0, st.min_count} + 7'd1;
        end
        m = min_inc[5:0];
        if (min_inc >= 7'd60) begin
          m        = 6'd0;
          hour_inc = {1'b0, st.hour_count} + 6'd1;
        end
        h = hour_inc[4:0];
        if (hour_inc >= 6'd24) begin
          h    = 5'd0;
          wrap = 1'b1;
        end
        st_next.sec_count  = s;
        st_next.min_count  = m;
        st_next.hour_count = h;
        if (h == st.alarm_hour && m == st.alarm_minute &&
            st.alarm_mode != MODE_OFF && s == 6'd0) begin
          st_next.buzzer     = 1'b1;
          st_next.alarm_mode = MODE_RINGING;
        end
        if (st_next.alarm_mode == MODE_RINGING && s == RING_SECS) begin
          st_next.buzzer     = 1'b0;
          st_next.alarm_mode = MODE_OFF;
        end
      end
      OP_NEXT, OP_SELECT, OP_PREV: begin
        if (st.page == PAGE_EDITOR) begin
          if (evt.opcode != OP_SELECT) begin
            if (!st.editing) begin
              st_next.item = up ? st.item + 2'd1 : st.item - 2'd1;
            end else if (st.item == ITEM_HOUR) begin
              if (up) begin
                st_next.alarm_hour = (st.alarm_hour >= HOUR_MAX) ? 5'd0
                                                                 : st.alarm_hour + 5'd1;
              end else begin
                st_next.alarm_hour = (st.alarm_hour == 5'd0) ? HOUR_MAX
                                                             : st.alarm_hour - 5'd1;
              end
            end else if (st.item == ITEM_MINUTE) begin
              if (up) begin
                st_next.alarm_minute = (st.alarm_minute >= MINSEC_MAX) ? 6'd0
                                                                       : st.alarm_minute + 6'd1;
              end else begin
                st_next.alarm_minute = (st.alarm_minute == 6'd0) ? MINSEC_MAX
                                                                 : st.alarm_minute - 6'd1;
              end
            end
          end else if (st.item == ITEM_BACK) begin
            st_next.page = PAGE_CLOCK;
          end else if (st.item == ITEM_ENABLE) begin
            if (st.alarm_mode == MODE_OFF) begin
              st_next.alarm_mode = MODE_ARMED;
            end else if (st.alarm_mode == MODE_ARMED) begin
              st_next.alarm_mode = MODE_OFF;
            end
          end else begin
            st_next.editing = ~st.editing;
          end
        end else if (evt.opcode == OP_NEXT) begin
          st_next.page = (st.page >= PAGE_RESET) ? PAGE_CLOCK : st.page + 2'd1;
        end else if (evt.opcode == OP_PREV) begin
          st_next.page = (st.page == PAGE_CLOCK) ? PAGE_RESET : st.page - 2'd1;
        end else if (st.page == PAGE_ENTRY) begin
          st_next.page = PAGE_EDITOR;
        end else if (st.page == PAGE_RESET) begin
          st_next.alarm_hour   = 5'd0;
          st_next.alarm_minute = 6'd0;
          st_next.alarm_mode   = MODE_OFF;
          st_next.buzzer       = 1'b0;
        end
      end
      OP_LOAD: begin
        st_next.hour_count = (evt.load_hour > HOUR_MAX) ? HOUR_MAX : evt.load_hour;
        st_next.min_count  = (evt.load_minute > MINSEC_MAX) ? MINSEC_MAX
                                                            : evt.load_minute;
        st_next.sec_count  = (evt.load_second > MINSEC_MAX) ? MINSEC_MAX
                                                            : evt.load_second;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/alarm_clock_with_menu.sv =====
// channel | valid     | stall     | payload
// event   | evt_valid | evt_stall | evt (acwm_pkg::evt_t)
// result  | res_valid | res_stall | res (acwm_pkg::res_t)
//
// One event per cycle sustained while res_stall is low; a result is registered
// after its event is taken (event register, state update, then result register).
// rst is synchronous: clears both valid flags and the whole clock/alarm/menu state.
// res_stall holds the result register; evt_stall rises only while the event
// register is full and the result register is full and stalled.
`default_nettype none
module alarm_clock_with_menu (
  input  logic             clk,
  input  logic             rst,
  input  logic             evt_valid,
  output logic             evt_stall,
  input  acwm_pkg::evt_t   evt,
  output logic             res_valid,
  input  logic             res_stall,
  output acwm_pkg::res_t   res
);
  import acwm_pkg::*;

  logic   held_valid;
  evt_t   held;
  state_t st;
  state_t st_next;
  logic   wrap;
  logic   adv;
  logic   res_open;

  acwm_step u_step (
    .st      (st),
    .evt     (held),
    .st_next (st_next),
    .wrap    (wrap)
  );

  assign res_open  = !res_valid || !res_stall;
  assign adv       = held_valid && res_open;
  assign evt_stall = held_valid && !res_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      res_valid  <= 1'b0;
      st         <= '0;
    end else begin
      if (!evt_stall) begin
        held_valid <= evt_valid;
      end
      if (res_open) begin
        res_valid <= held_valid;
      end
      if (adv) begin
        st <= st_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!evt_stall && evt_valid) begin
      held <= evt;
    end
    if (adv) begin
      res.hour           <= st_next.hour_count;
      res.minute         <= st_next.min_count;
      res.second         <= st_next.sec_count;
      res.buzzer         <= st_next.buzzer;
      res.alarm_mode     <= st_next.alarm_mode;
      res.alarm_hour     <= st_next.alarm_hour;
      res.alarm_minute   <= st_next.alarm_minute;
      res.menu_page      <= st_next.page;
      res.edit_item      <= st_next.item;
      res.editing        <= st_next.editing;
      res.resync_request <= wrap;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/acwm_check.sv =====
`default_nettype none
module acwm_check (
  input logic           clk,
  input logic           rst,
  input logic           res_valid,
  input logic           res_stall,
  input acwm_pkg::res_t res
);
  import acwm_pkg::*;

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  a_buzz_mode: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.buzzer == (res.alarm_mode == MODE_RINGING))
    else $error("buzzer disagrees with alarm mode");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.hour <= HOUR_MAX && res.minute <= MINSEC_MAX &&
                  res.second <= MINSEC_MAX)
    else $error("time out of range");

  a_edit_ctx: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.editing |-> res.menu_page == PAGE_EDITOR &&
      (res.edit_item == ITEM_HOUR || res.edit_item == ITEM_MINUTE))
    else $error("editing outside hour or minute line");

  a_wrap_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.resync_request |-> res.hour == 5'd0 && res.minute == 6'd0 &&
                                       res.second == 6'd0)
    else $error("resync without midnight");

endmodule

bind alarm_clock_with_menu acwm_check u_check (.*);
`default_nettype wire
